[hdl/sdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg: shared constants and types of the decimal digit formatter
// Digit codes, range limits, the reciprocal for divide by ten and the word
// that one cell hands to the next.
// ----------------------------------------------------------------------------
package sdf_pkg;

   localparam int NUM_POSITIONS = 8;
   localparam int CODE_W        = 4;
   localparam int CODES_W       = NUM_POSITIONS * CODE_W;
   localparam int CNT_W         = $clog2(NUM_POSITIONS + 1);
   localparam int VALUE_W       = 32;
   localparam int COUNT_IN_W    = 4;

   localparam logic [CODE_W-1:0] CODE_ZERO  = 4'd0;
   localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
   localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

   localparam logic [VALUE_W-1:0] POS_LIMIT = 32'd99999999;
   localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'd999999;

   // floor(x / 10) = (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
   localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               minus;
      logic               first;
      logic [CNT_W-1:0]   remain;
      logic               oor;
      logic [CODES_W-1:0] codes;
   } cell_data_type;

endpackage
`default_nettype wire

[hdl/sdf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_cell: one digit position of the formatter chain
// Split off the lowest decimal digit, pick the display code for this position
// and hand the quotient and the code word on to the next cell.
// ----------------------------------------------------------------------------
module sdf_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  valid_in,
   input  wire sdf_pkg::cell_data_type data_in,
   output logic                       valid_out,
   output sdf_pkg::cell_data_type     data_out
);

   logic                           valid_ff;
   logic                           valid_in_w;
   sdf_pkg::cell_data_type         data_ff;
   sdf_pkg::cell_data_type         data_in_w;
   logic [2*sdf_pkg::VALUE_W-1:0]  prod;
   logic [sdf_pkg::VALUE_W-1:0]    quot;
   logic [sdf_pkg::VALUE_W-1:0]    quot_x10;
   logic [sdf_pkg::CODE_W-1:0]     digit;
   logic [sdf_pkg::CODE_W-1:0]     code;
   logic                           in_win;

   assign prod     = data_in.mag * sdf_pkg::RECIP10;
   assign quot     = sdf_pkg::VALUE_W'(prod >> sdf_pkg::RECIP_SHIFT);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign digit    = sdf_pkg::CODE_W'(data_in.mag - quot_x10);
   assign in_win   = (data_in.remain != '0);

   always_comb begin
      data_in_w       = data_in;
      data_in_w.first = 1'b0;
      code            = sdf_pkg::CODE_BLANK;
      if (in_win) begin
         if (data_in.mag != '0) begin
            code = digit;
         end else if (data_in.minus) begin
            code = sdf_pkg::CODE_MINUS;
            data_in_w.minus = 1'b0;
         end else if (data_in.first) begin
            code = sdf_pkg::CODE_ZERO;
         end
         data_in_w.mag    = quot;
         data_in_w.remain = data_in.remain - sdf_pkg::CNT_W'(1);
      end
      // shift the code in from the top: the first cell ends up lowest
      data_in_w.codes = (data_in.codes >> sdf_pkg::CODE_W)
                      | (sdf_pkg::CODES_W'(code) << (sdf_pkg::CODES_W - sdf_pkg::CODE_W));
   end

   assign valid_in_w = advance ? valid_in : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_w;
      end
      if (advance) begin
         data_ff <= data_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire

[hdl/sdf_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_serializer: result channel of the formatter
// Hold the finished code word of one item and send one position per beat,
// lowest position first, taking the next word as the last beat leaves.
// ----------------------------------------------------------------------------
module sdf_serializer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         tail_valid,
   input  wire sdf_pkg::cell_data_type       tail_data,
   output logic                              can_load,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [7:0]                        rsp_tdata,  // position, digit_code
   output logic                              rsp_tuser,  // out_of_range
   output logic                              rsp_tlast
);

   logic                         valid_ff, valid_in;
   logic [sdf_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [sdf_pkg::CODES_W-1:0]  codes_ff, codes_in;
   logic                         oor_ff, oor_in;
   logic                         last_w;
   logic                         load;

   assign last_w   = (idx_ff == sdf_pkg::CNT_W'(sdf_pkg::NUM_POSITIONS - 1));
   assign can_load = !valid_ff || (rsp_tready && last_w);
   assign load     = tail_valid && can_load;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      codes_in = codes_ff;
      oor_in   = oor_ff;
      if (valid_ff && rsp_tready) begin
         if (last_w) begin
            valid_in = 1'b0;
         end else begin
            idx_in   = idx_ff + sdf_pkg::CNT_W'(1);
            codes_in = codes_ff >> sdf_pkg::CODE_W;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
         codes_in = tail_data.codes;
         oor_in   = tail_data.oor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      codes_ff <= codes_in;
      oor_ff   <= oor_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {codes_ff[sdf_pkg::CODE_W-1:0], 4'(idx_ff + 1'b1)};
   assign rsp_tuser  = oor_ff;
   assign rsp_tlast  = last_w;

endmodule
`default_nettype wire

[hdl/signed_decimal_digit_formatter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_digit_formatter: signed value to decimal display codes
// Path: the first result beat follows the input beat through the entry
//   register, one cell per position and the output register.
// Flow: one digit per result beat on the single result channel; the
//   cell chain holds further items meanwhile.
// Reset: synchronous, clears the valid bits of the chain and the output.
// ----------------------------------------------------------------------------
module signed_decimal_digit_formatter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // value[31:0], digit_count[35:32], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // position[3:0], digit_code[7:4]
   output logic             rsp_tuser,   // out_of_range
   output logic             rsp_tlast
);

   localparam int N = sdf_pkg::NUM_POSITIONS;

   logic                        advance;
   logic                        can_load;
   logic                        front_valid_ff, front_valid_in;
   sdf_pkg::cell_data_type      front_ff, front_in;
   logic [sdf_pkg::VALUE_W-1:0] raw;
   logic [sdf_pkg::VALUE_W-1:0] mag;
   logic                        neg;
   logic [4:0]                  cnt_wide;
   logic [4:0]                  cnt_sat;

   logic                        chain_valid [0:N];
   sdf_pkg::cell_data_type      chain_data  [0:N];

   assign raw      = req_tdata[31:0];
   assign neg      = raw[sdf_pkg::VALUE_W-1];
   assign mag      = neg ? (sdf_pkg::VALUE_W'(0) - raw) : raw;
   assign cnt_wide = 5'(req_tdata[35:32]);
   assign cnt_sat  = (cnt_wide > 5'(N)) ? 5'(N) : cnt_wide;

   always_comb begin
      front_in.mag    = mag;
      front_in.minus  = neg;
      front_in.first  = 1'b1;
      front_in.remain = sdf_pkg::CNT_W'(cnt_sat);
      front_in.oor    = neg ? (mag > sdf_pkg::NEG_LIMIT) : (raw > sdf_pkg::POS_LIMIT);
      front_in.codes  = '0;
   end

   assign advance        = !chain_valid[N] || can_load;
   assign req_tready     = advance;
   assign front_valid_in = advance ? req_tvalid : front_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (advance) begin
         front_ff <= front_in;
      end
   end

   assign chain_valid[0] = front_valid_ff;
   assign chain_data[0]  = front_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      sdf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (chain_valid[i]),
         .data_in   (chain_data[i]),
         .valid_out (chain_valid[i+1]),
         .data_out  (chain_data[i+1])
      );
   end

   sdf_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .tail_valid (chain_valid[N]),
      .tail_data  (chain_data[N]),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3:0] == 4'(N))
      else $error("last beat not at final position");

   a_position_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1))
      else $error("position did not advance by one");

   a_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:4] <= sdf_pkg::CODE_MINUS)
                  || (rsp_tdata[7:4] == sdf_pkg::CODE_BLANK))
      else $error("unused digit code on result");

endmodule
`default_nettype wire
